@@ hdl/task_priority_queue_macros.svh @@
// Assertion macros for the checker file of the task priority queue.
`ifndef TASK_PRIORITY_QUEUE_MACROS_SVH
`define TASK_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define TPQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define TPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tpq_pkg.sv @@
`default_nettype none
package tpq_pkg;

  // Field widths of one transaction.
  localparam int ACT_W  = 2;
  localparam int ID_W   = 8;
  localparam int PRIO_W = 8;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;

  localparam int QUEUE_DEPTH_DEFAULT = 64;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DQH  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DQI  = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  // Sequencing mode of one microinstruction.
  typedef enum logic [2:0] {
    SQ_NEXT,
    SQ_JUMP,
    SQ_BR_T,
    SQ_BR_F,
    SQ_DISPATCH
  } seq_t;

  // Branch conditions reported by the datapath.
  typedef enum logic [1:0] {
    C_FULL,
    C_EMPTY,
    C_MORE,
    C_MATCH
  } cond_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ENQ,
    OP_SET_FULL,
    OP_SET_NF,
    OP_CLR_SCAN,
    OP_RD_IDX,
    OP_BEST_CMP,
    OP_BEST_TAKE,
    OP_INC_IDX,
    OP_ID_HIT,
    OP_RD_NEXT,
    OP_SHIFT_WR,
    OP_DEC
  } dp_op_t;

  // Microprogram addresses.
  typedef enum logic [4:0] {
    U_IDLE     = 5'd0,
    U_ENQ      = 5'd1,
    U_ENQ_WR   = 5'd2,
    U_FULL     = 5'd3,
    U_FAIL     = 5'd4,
    U_DQH      = 5'd5,
    U_DQH_RD   = 5'd6,
    U_DQH_CMP  = 5'd7,
    U_DQH_TAKE = 5'd8,
    U_DQI      = 5'd9,
    U_DQI_RD   = 5'd10,
    U_DQI_CMP  = 5'd11,
    U_DQI_NXT  = 5'd12,
    U_DQI_MISS = 5'd13,
    U_DQI_HIT  = 5'd14,
    U_SHIFT_RD = 5'd15,
    U_SHIFT_WR = 5'd16,
    U_DEC      = 5'd17,
    U_EMIT     = 5'd18
  } upc_t;

  // One control word.
  typedef struct packed {
    seq_t   seq;
    cond_t  cond;
    upc_t   target;
    dp_op_t op;
    logic   emit;
  } ctl_t;

  // Condition flags from the datapath to the sequencer.
  typedef struct packed {
    logic full;
    logic empty;
    logic more;
    logic match;
  } sts_t;

  function automatic ctl_t mk(seq_t s, cond_t c, upc_t t, dp_op_t o, logic e);
    ctl_t w;
    w.seq    = s;
    w.cond   = c;
    w.target = t;
    w.op     = o;
    w.emit   = e;
    return w;
  endfunction

  // Control store: one word per microprogram step.
  function automatic ctl_t rom(upc_t pc);
    ctl_t w;
    unique case (pc)
      U_IDLE:     w = mk(SQ_DISPATCH, C_FULL,  U_IDLE,     OP_LATCH,     1'b0);
      U_ENQ:      w = mk(SQ_BR_T,     C_FULL,  U_FULL,     OP_NONE,      1'b0);
      U_ENQ_WR:   w = mk(SQ_JUMP,     C_FULL,  U_EMIT,     OP_ENQ,       1'b0);
      U_FULL:     w = mk(SQ_JUMP,     C_FULL,  U_EMIT,     OP_SET_FULL,  1'b0);
      U_FAIL:     w = mk(SQ_JUMP,     C_FULL,  U_EMIT,     OP_SET_NF,    1'b0);
      U_DQH:      w = mk(SQ_BR_T,     C_EMPTY, U_FAIL,     OP_CLR_SCAN,  1'b0);
      U_DQH_RD:   w = mk(SQ_NEXT,     C_FULL,  U_IDLE,     OP_RD_IDX,    1'b0);
      U_DQH_CMP:  w = mk(SQ_BR_T,     C_MORE,  U_DQH_RD,   OP_BEST_CMP,  1'b0);
      U_DQH_TAKE: w = mk(SQ_JUMP,     C_FULL,  U_SHIFT_RD, OP_BEST_TAKE, 1'b0);
      U_DQI:      w = mk(SQ_BR_T,     C_EMPTY, U_FAIL,     OP_CLR_SCAN,  1'b0);
      U_DQI_RD:   w = mk(SQ_NEXT,     C_FULL,  U_IDLE,     OP_RD_IDX,    1'b0);
      U_DQI_CMP:  w = mk(SQ_BR_T,     C_MATCH, U_DQI_HIT,  OP_NONE,      1'b0);
      U_DQI_NXT:  w = mk(SQ_BR_T,     C_MORE,  U_DQI_RD,   OP_INC_IDX,   1'b0);
      U_DQI_MISS: w = mk(SQ_JUMP,     C_FULL,  U_FAIL,     OP_NONE,      1'b0);
      U_DQI_HIT:  w = mk(SQ_JUMP,     C_FULL,  U_SHIFT_RD, OP_ID_HIT,    1'b0);
      U_SHIFT_RD: w = mk(SQ_BR_F,     C_MORE,  U_DEC,      OP_RD_NEXT,   1'b0);
      U_SHIFT_WR: w = mk(SQ_JUMP,     C_FULL,  U_SHIFT_RD, OP_SHIFT_WR,  1'b0);
      U_DEC:      w = mk(SQ_NEXT,     C_FULL,  U_IDLE,     OP_DEC,       1'b0);
      U_EMIT:     w = mk(SQ_JUMP,     C_FULL,  U_IDLE,     OP_NONE,      1'b1);
      default:    w = mk(SQ_JUMP,     C_FULL,  U_IDLE,     OP_NONE,      1'b0);
    endcase
    return w;
  endfunction

  // Entry point of the routine for each action; the unused code fails.
  function automatic upc_t dispatch(logic [ACT_W-1:0] act);
    upc_t t;
    unique case (act)
      ACT_ENQ: t = U_ENQ;
      ACT_DQH: t = U_DQH;
      ACT_DQI: t = U_DQI;
      default: t = U_FAIL;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

@@ hdl/tpq_mem.sv @@
`default_nettype none
module tpq_mem #(
  parameter int DEPTH = tpq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int WIDTH = tpq_pkg::ID_W + tpq_pkg::PRIO_W,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ hdl/tpq_seq.sv @@
`default_nettype none
module tpq_seq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tpq_pkg::ACT_W-1:0]  in_action,
  input  wire tpq_pkg::sts_t              sts,
  output tpq_pkg::ctl_t                   ctl,
  output logic                            busy
);

  tpq_pkg::upc_t pc_r;
  tpq_pkg::upc_t pc_nxt;
  logic          cond_val;

  // Select the branch condition named by the control word.
  always_comb begin
    case (ctl.cond)
      tpq_pkg::C_FULL:  cond_val = sts.full;
      tpq_pkg::C_EMPTY: cond_val = sts.empty;
      tpq_pkg::C_MORE:  cond_val = sts.more;
      tpq_pkg::C_MATCH: cond_val = sts.match;
      default:          cond_val = 1'b0;
    endcase
  end

  // Next microprogram address.
  always_comb begin
    unique case (ctl.seq)
      tpq_pkg::SQ_NEXT:     pc_nxt = tpq_pkg::upc_t'(5'(pc_r + 5'd1));
      tpq_pkg::SQ_JUMP:     pc_nxt = ctl.target;
      tpq_pkg::SQ_BR_T:     pc_nxt = cond_val ? ctl.target : tpq_pkg::upc_t'(5'(pc_r + 5'd1));
      tpq_pkg::SQ_BR_F:     pc_nxt = cond_val ? tpq_pkg::upc_t'(5'(pc_r + 5'd1)) : ctl.target;
      tpq_pkg::SQ_DISPATCH: pc_nxt = start ? tpq_pkg::dispatch(in_action) : pc_r;
      default:              pc_nxt = tpq_pkg::U_IDLE;
    endcase
  end

  // Control word fetch and busy flag.
  always_comb begin
    ctl  = tpq_pkg::rom(pc_r);
    busy = (pc_r != tpq_pkg::U_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tpq_pkg::U_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/tpq_dp.sv @@
`default_nettype none
module tpq_dp #(
  parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tpq_pkg::ctl_t               ctl,
  input  wire logic [tpq_pkg::ID_W-1:0]    in_task_id,
  input  wire logic [tpq_pkg::PRIO_W-1:0]  in_priority_req,
  output tpq_pkg::sts_t                    sts,
  output logic                             out_valid,
  output logic [tpq_pkg::ID_W-1:0]         out_result_id,
  output logic [tpq_pkg::ST_W-1:0]         out_status,
  output logic [tpq_pkg::CNT_W-1:0]        out_entry_count
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = tpq_pkg::ID_W + tpq_pkg::PRIO_W;

  logic [CW-1:0]              occ_r, occ_nxt;
  logic [IW-1:0]              idx_r, idx_nxt;
  logic [IW-1:0]              best_idx_r, best_idx_nxt;
  logic [tpq_pkg::PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [tpq_pkg::ID_W-1:0]   best_id_r, best_id_nxt;
  logic                       found_r, found_nxt;
  logic [tpq_pkg::ID_W-1:0]   tid_r, tid_nxt;
  logic [tpq_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [tpq_pkg::ID_W-1:0]   rid_r, rid_nxt;
  logic [tpq_pkg::ST_W-1:0]   st_r, st_nxt;
  logic                       valid_r;
  logic [tpq_pkg::ID_W-1:0]   res_id_r;
  logic [tpq_pkg::ST_W-1:0]   res_st_r;
  logic [tpq_pkg::CNT_W-1:0]  res_cnt_r;

  logic                       wr_en;
  logic [IW-1:0]              wr_addr;
  logic [EW-1:0]              wr_data;
  logic                       rd_en;
  logic [IW-1:0]              rd_addr;
  logic [EW-1:0]              rd_data;
  logic [tpq_pkg::ID_W-1:0]   rd_id;
  logic [tpq_pkg::PRIO_W-1:0] rd_prio;
  logic [IW-1:0]              idx_inc;

  tpq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_id   = rd_data[EW-1:tpq_pkg::PRIO_W];
  assign rd_prio = rd_data[tpq_pkg::PRIO_W-1:0];
  assign idx_inc = IW'(idx_r + IW'(1));

  // Condition flags for the sequencer.
  always_comb begin
    sts.full  = (occ_r == CW'(QUEUE_DEPTH));
    sts.empty = (occ_r == '0);
    sts.more  = ((CW+1)'(idx_r) + (CW+1)'(1)) < (CW+1)'(occ_r);
    sts.match = (rd_id == tid_r);
  end

  // Memory port control.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = idx_r;
    case (ctl.op)
      tpq_pkg::OP_ENQ: begin
        wr_en   = 1'b1;
        wr_addr = IW'(occ_r);
        wr_data = {tid_r, prio_r};
      end
      tpq_pkg::OP_SHIFT_WR: begin
        wr_en = 1'b1;
      end
      tpq_pkg::OP_RD_IDX: begin
        rd_en = 1'b1;
      end
      tpq_pkg::OP_RD_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = idx_inc;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Register updates for each datapath operation.
  always_comb begin
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    best_id_nxt   = best_id_r;
    found_nxt     = found_r;
    tid_nxt       = tid_r;
    prio_nxt      = prio_r;
    rid_nxt       = rid_r;
    st_nxt        = st_r;
    case (ctl.op)
      tpq_pkg::OP_LATCH: begin
        tid_nxt  = in_task_id;
        prio_nxt = in_priority_req;
      end
      tpq_pkg::OP_ENQ: begin
        occ_nxt = CW'(occ_r + CW'(1));
        rid_nxt = tid_r;
        st_nxt  = tpq_pkg::ST_OK;
      end
      tpq_pkg::OP_SET_FULL: begin
        rid_nxt = '0;
        st_nxt  = tpq_pkg::ST_FULL;
      end
      tpq_pkg::OP_SET_NF: begin
        rid_nxt = '0;
        st_nxt  = tpq_pkg::ST_NOT_FOUND;
      end
      tpq_pkg::OP_CLR_SCAN: begin
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end
      tpq_pkg::OP_BEST_CMP: begin
        // Strictly greater keeps the earliest entry among equal priorities.
        if (!found_r || (rd_prio > best_prio_r)) begin
          best_idx_nxt  = idx_r;
          best_prio_nxt = rd_prio;
          best_id_nxt   = rd_id;
        end
        found_nxt = 1'b1;
        idx_nxt   = idx_inc;
      end
      tpq_pkg::OP_BEST_TAKE: begin
        idx_nxt = best_idx_r;
        rid_nxt = best_id_r;
        st_nxt  = tpq_pkg::ST_OK;
      end
      tpq_pkg::OP_INC_IDX: begin
        idx_nxt = idx_inc;
      end
      tpq_pkg::OP_ID_HIT: begin
        rid_nxt = rd_id;
        st_nxt  = tpq_pkg::ST_OK;
      end
      tpq_pkg::OP_SHIFT_WR: begin
        idx_nxt = idx_inc;
      end
      tpq_pkg::OP_DEC: begin
        occ_nxt = CW'(occ_r - CW'(1));
      end
      default: begin
        occ_nxt = occ_r;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      occ_r   <= occ_nxt;
      valid_r <= ctl.emit;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    best_id_r   <= best_id_nxt;
    found_r     <= found_nxt;
    tid_r       <= tid_nxt;
    prio_r      <= prio_nxt;
    rid_r       <= rid_nxt;
    st_r        <= st_nxt;
    if (ctl.emit) begin
      res_id_r  <= rid_r;
      res_st_r  <= st_r;
      res_cnt_r <= tpq_pkg::CNT_W'(occ_r);
    end
  end

  assign out_valid       = valid_r;
  assign out_result_id   = res_id_r;
  assign out_status      = res_st_r;
  assign out_entry_count = res_cnt_r;

endmodule
`default_nettype wire

@@ hdl/task_priority_queue.sv @@
`default_nettype none
// Channel   Ports                                         Handshake
// input     in_action, in_task_id, in_priority_req        start high and busy low
// result    out_result_id, out_status, out_entry_count    out_valid high for one cycle
//
// Each action runs as a microprogram routine. Dequeue by priority scans all N entries held,
// dequeue by id scans the P entries ahead of the match (all N on a missed id), and a removal
// shifts forward the M entries behind the removed one; the memory reads one slot per cycle,
// registered.
// Reset clears the entry count and the sequencer; no clearing pass is needed.
// The receiver cannot stall; the next transaction may be accepted while the strobe is high.
module task_priority_queue #(
  parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [tpq_pkg::ACT_W-1:0]   in_action,
  input  wire logic [tpq_pkg::ID_W-1:0]    in_task_id,
  input  wire logic [tpq_pkg::PRIO_W-1:0]  in_priority_req,
  output logic                             out_valid,
  output logic [tpq_pkg::ID_W-1:0]         out_result_id,
  output logic [tpq_pkg::ST_W-1:0]         out_status,
  output logic [tpq_pkg::CNT_W-1:0]        out_entry_count
);

  tpq_pkg::ctl_t ctl;
  tpq_pkg::sts_t sts;

  // Microprogram sequencer.
  tpq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy)
  );

  // Queue datapath with the entry memory.
  tpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_result_id   (out_result_id),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire

@@ hdl/tpq_chk.sv @@
`default_nettype none
`include "task_priority_queue_macros.svh"
module tpq_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic [tpq_pkg::ID_W-1:0]    out_result_id,
  input wire logic [tpq_pkg::ST_W-1:0]    out_status
);

  logic accept;
  assign accept = start && !busy;

  // An accepted transaction keeps the block busy in the following cycle.
  `TPQ_ASSERT_NEXT(a_busy_after_accept, accept, busy, "not busy after accept")

  // Results never come in consecutive cycles.
  `TPQ_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held")

  // A failed action returns a zero id.
  `TPQ_ASSERT_SAME(a_fail_zero_id,
    out_valid && (out_status != tpq_pkg::ST_OK), out_result_id == '0,
    "nonzero id on failed action")

  // Only the three defined status codes appear.
  `TPQ_ASSERT_SAME(a_status_code, out_valid,
    (out_status == tpq_pkg::ST_OK) || (out_status == tpq_pkg::ST_NOT_FOUND) ||
    (out_status == tpq_pkg::ST_FULL), "undefined status code")

endmodule

bind task_priority_queue tpq_chk u_chk (.*);
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = tpq_pkg::QUEUE_DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int IDLE_PERCENT   = 14;
  // Items in this range of the run never see an idle gap on the input side.
  localparam int STEADY_FIRST   = 900;
  localparam int STEADY_LAST    = 1250;
  localparam int SETTLE_CYCLES  = 300;
  localparam int QUIET_LIMIT    = 2000;

  // This code has no meaning and must leave the queue untouched.
  localparam logic [tpq_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [tpq_pkg::ID_W-1:0]  id;
    logic [tpq_pkg::ST_W-1:0]  status;
    logic [tpq_pkg::CNT_W-1:0] count;
  } outcome_t;

  typedef struct packed {
    logic [tpq_pkg::ACT_W-1:0]  act;
    logic [tpq_pkg::ID_W-1:0]   id;
    logic [tpq_pkg::PRIO_W-1:0] prio;
    logic                       typed;
    outcome_t                   want;
  } vector_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic [tpq_pkg::ACT_W-1:0]    in_action;
  logic [tpq_pkg::ID_W-1:0]     in_task_id;
  logic [tpq_pkg::PRIO_W-1:0]   in_priority_req;
  logic                         out_valid;
  logic [tpq_pkg::ID_W-1:0]     out_result_id;
  logic [tpq_pkg::ST_W-1:0]     out_status;
  logic [tpq_pkg::CNT_W-1:0]    out_entry_count;

  // Shadow copy of the queue contents, oldest entry first.
  logic [tpq_pkg::ID_W-1:0]     held_ids[$];
  logic [tpq_pkg::PRIO_W-1:0]   held_prios[$];
  outcome_t                     pending_results[$];
  int                           mismatch_count = 0;
  int                           quiet_cycles = 0;
  int                           item_index = 0;

  // Directed transactions. Rows with typed set carry an expected outcome that
  // follows directly from the queue contents; the others use the predictor.
  vector_t directed_rows [0:24] = '{
    '{tpq_pkg::ACT_DQH, 8'h00, 8'h00, 1'b1, '{8'h00, tpq_pkg::ST_NOT_FOUND, 7'd0}},
    '{tpq_pkg::ACT_DQI, 8'hFF, 8'hFF, 1'b1, '{8'h00, tpq_pkg::ST_NOT_FOUND, 7'd0}},
    '{ACT_UNUSED,       8'hA5, 8'h5A, 1'b1, '{8'h00, tpq_pkg::ST_NOT_FOUND, 7'd0}},
    '{tpq_pkg::ACT_ENQ, 8'hFF, 8'h00, 1'b1, '{8'hFF, tpq_pkg::ST_OK,        7'd1}},
    '{tpq_pkg::ACT_DQH, 8'h00, 8'hFF, 1'b1, '{8'hFF, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_ENQ, 8'hFF, 8'h00, 1'b1, '{8'hFF, tpq_pkg::ST_OK,        7'd1}},
    '{tpq_pkg::ACT_ENQ, 8'h00, 8'hFF, 1'b1, '{8'h00, tpq_pkg::ST_OK,        7'd2}},
    '{tpq_pkg::ACT_ENQ, 8'h55, 8'hFF, 1'b1, '{8'h55, tpq_pkg::ST_OK,        7'd3}},
    '{tpq_pkg::ACT_ENQ, 8'hAA, 8'h80, 1'b1, '{8'hAA, tpq_pkg::ST_OK,        7'd4}},
    '{tpq_pkg::ACT_DQH, 8'h3C, 8'hC3, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_DQH, 8'hC3, 8'h3C, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_DQI, 8'h77, 8'h00, 1'b1, '{8'h00, tpq_pkg::ST_NOT_FOUND, 7'd2}},
    '{ACT_UNUSED,       8'hFF, 8'hFF, 1'b1, '{8'h00, tpq_pkg::ST_NOT_FOUND, 7'd2}},
    '{tpq_pkg::ACT_ENQ, 8'h12, 8'h05, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_ENQ, 8'h12, 8'h09, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_DQI, 8'h12, 8'h00, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_DQI, 8'hFF, 8'h00, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_DQH, 8'h00, 8'h00, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_DQH, 8'h00, 8'h00, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_DQH, 8'h00, 8'h00, 1'b1, '{8'h00, tpq_pkg::ST_NOT_FOUND, 7'd0}},
    '{tpq_pkg::ACT_ENQ, 8'h01, 8'h01, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_ENQ, 8'h02, 8'h01, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_DQH, 8'h00, 8'h00, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_DQI, 8'h02, 8'h00, 1'b0, '{8'h00, tpq_pkg::ST_OK,        7'd0}},
    '{tpq_pkg::ACT_DQI, 8'h02, 8'h00, 1'b1, '{8'h00, tpq_pkg::ST_NOT_FOUND, 7'd0}}
  };

  task_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_action(in_action),
    .in_task_id(in_task_id),
    .in_priority_req(in_priority_req),
    .out_valid(out_valid),
    .out_result_id(out_result_id),
    .out_status(out_status),
    .out_entry_count(out_entry_count)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Apply one action to the shadow queue and return the outcome it should give.
  function automatic outcome_t apply_action(logic [tpq_pkg::ACT_W-1:0] act,
                                            logic [tpq_pkg::ID_W-1:0] id,
                                            logic [tpq_pkg::PRIO_W-1:0] prio);
    outcome_t r;
    int       best;
    int       k;
    bit       hit;
    r.id     = '0;
    r.status = tpq_pkg::ST_NOT_FOUND;
    hit      = 1'b0;
    case (act)
      tpq_pkg::ACT_ENQ: begin
        if (held_ids.size() >= DEPTH) begin
          r.status = tpq_pkg::ST_FULL;
        end else begin
          held_ids.push_back(id);
          held_prios.push_back(prio);
          r.id     = id;
          r.status = tpq_pkg::ST_OK;
        end
      end
      tpq_pkg::ACT_DQH: begin
        if (held_ids.size() > 0) begin
          // Strictly greater keeps the earliest arrival on a tie.
          best = 0;
          for (k = 1; k < held_prios.size(); k++) begin
            if (held_prios[k] > held_prios[best]) best = k;
          end
          r.id     = held_ids[best];
          r.status = tpq_pkg::ST_OK;
          held_ids.delete(best);
          held_prios.delete(best);
        end
      end
      tpq_pkg::ACT_DQI: begin
        for (k = 0; k < held_ids.size() && !hit; k++) begin
          if (held_ids[k] == id) begin
            hit      = 1'b1;
            r.id     = id;
            r.status = tpq_pkg::ST_OK;
            held_ids.delete(k);
            held_prios.delete(k);
          end
        end
      end
      default: ;
    endcase
    r.count = tpq_pkg::CNT_W'(held_ids.size());
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Present one transaction at a falling edge and hold it until accepted.
  task automatic send_item(input logic [tpq_pkg::ACT_W-1:0] act,
                           input logic [tpq_pkg::ID_W-1:0] id,
                           input logic [tpq_pkg::PRIO_W-1:0] prio, input logic typed,
                           input outcome_t want);
    outcome_t predicted;
    in_action       = act;
    in_task_id      = id;
    in_priority_req = prio;
    start           = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_action(act, id, prio);
    pending_results.push_back(typed ? want : predicted);
    item_index++;
    @(negedge clk);
  endtask

  function automatic logic [tpq_pkg::ACT_W-1:0] ACT_WIDTH_RANDOM();
    return tpq_pkg::ACT_W'($urandom);
  endfunction

  // Sometimes drop start, with random inputs, before the next transaction.
  task automatic idle_gap();
    if ((item_index < STEADY_FIRST || item_index > STEADY_LAST) &&
        $urandom_range(0, 99) < IDLE_PERCENT) begin
      start           = 1'b0;
      in_action       = ACT_WIDTH_RANDOM();
      in_task_id      = tpq_pkg::ID_W'($urandom);
      in_priority_req = tpq_pkg::PRIO_W'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // Pick an action according to the current mix of the burst.
  function automatic logic [tpq_pkg::ACT_W-1:0] pick_action(mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return (roll < 75) ? tpq_pkg::ACT_ENQ : (roll < 87) ? tpq_pkg::ACT_DQH :
                        (roll < 97) ? tpq_pkg::ACT_DQI : ACT_UNUSED;
      MIX_DRAIN: return (roll < 15) ? tpq_pkg::ACT_ENQ : (roll < 55) ? tpq_pkg::ACT_DQH :
                        (roll < 97) ? tpq_pkg::ACT_DQI : ACT_UNUSED;
      default:   return (roll < 40) ? tpq_pkg::ACT_ENQ : (roll < 70) ? tpq_pkg::ACT_DQH :
                        (roll < 97) ? tpq_pkg::ACT_DQI : ACT_UNUSED;
    endcase
  endfunction

  // Compare each result strobe against the oldest outstanding expectation.
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result_id with no transaction outstanding", out_result_id, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_result_id !== want.id)
          report_mismatch("result_id", out_result_id, want.id);
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", out_entry_count, want.count);
      end
    end
  end

  // End the run if neither side accepts anything for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
        $display("task_priority_queue verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus: reset, the directed rows, then bursts of random transactions.
  initial begin
    mix_t                       mix;
    int                         burst_left;
    int                         n;
    int                         roll;
    logic [tpq_pkg::ACT_W-1:0]  act;
    logic [tpq_pkg::ID_W-1:0]   id;
    logic [tpq_pkg::PRIO_W-1:0] prio;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = tpq_pkg::ACT_ENQ;
    in_task_id      = '0;
    in_priority_req = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      idle_gap();
      send_item(directed_rows[i].act, directed_rows[i].id, directed_rows[i].prio,
                directed_rows[i].typed, directed_rows[i].want);
    end

    mix        = MIX_FILL;
    burst_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Bursts that fill, drain or mix, so both the full and empty ends are hit.
      if (burst_left == 0) begin
        roll       = $urandom_range(0, 2);
        mix        = (roll == 0) ? MIX_FILL : (roll == 1) ? MIX_DRAIN : MIX_EVEN;
        burst_left = $urandom_range(100, 200);
      end
      burst_left--;
      act = pick_action(mix);

      // Ids half the time from a small set so duplicates occur; priorities often tie.
      roll = $urandom_range(0, 3);
      id   = (roll < 2) ? tpq_pkg::ID_W'($urandom) : tpq_pkg::ID_W'($urandom_range(0, 7));
      roll = $urandom_range(0, 3);
      case (roll)
        0, 1:    prio = tpq_pkg::PRIO_W'($urandom);
        2:       prio = tpq_pkg::PRIO_W'($urandom_range(0, 3));
        default: prio = $urandom_range(0, 1) ? '1 : '0;
      endcase

      // Removal by id mostly names an entry that is actually queued.
      if (act == tpq_pkg::ACT_DQI && held_ids.size() > 0 && $urandom_range(0, 99) < 80)
        id = held_ids[$urandom_range(0, held_ids.size() - 1)];

      idle_gap();
      send_item(act, id, prio, 1'b0, '0);
    end

    // Drain the outstanding results, then watch for strays.
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("task_priority_queue verification clean");
    end else begin
      $display("task_priority_queue verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/tpq_pkg.sv
hdl/tpq_mem.sv
hdl/tpq_seq.sv
hdl/tpq_dp.sv
hdl/task_priority_queue.sv
hdl/tpq_chk.sv
verif/tb_top.sv
